// ===== hdl/segment_intersection_test_assert.svh =====
// Assertion macros for the checker file of the segment intersection block.
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent, outside reset.
`define SIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

// Checks the cycle after the antecedent, including cycles in reset.
`define SIT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication during reset.");

`endif

// ===== hdl/sit_pkg.sv =====
// Shared constants for the segment intersection block.
package sit_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int N_COORDS        = 8;

    localparam int CASE_W = 2;
    localparam logic [CASE_W-1:0] CASE_GENERAL  = 2'd0;
    localparam logic [CASE_W-1:0] CASE_ON_LINE  = 2'd1;
    localparam logic [CASE_W-1:0] CASE_PARALLEL = 2'd2;

    localparam int OUT_TDATA_W = 8;

endpackage

// ===== hdl/segment_intersection_test.sv =====
// Top level of the pipelined 2D segment intersection test.
//
//  channel   dir  tdata (low bit up)                                  tuser
//  s_axis    in   first_start_x, first_start_y, first_end_x,          -
//                 first_end_y, second_start_x, second_start_y,
//                 second_end_x, second_end_y (COORD_WIDTH each)
//  m_axis    out  hit, zero padding to 8 bits                         case_code
//
// One request per cycle is accepted while s_axis_tready is high.
// The stages are: coordinate differences, six products, three cross products, result.
// Each stage holds its item until the next stage can take it, so bubbles are squeezed out
// and a stalled output does not block requests until all four stages are full.
// Reset clears the stage valid bits only.
module segment_intersection_test #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [sit_pkg::N_COORDS*COORD_WIDTH-1:0]    s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // hit, then zero padding
    output logic [sit_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,
    // case_code
    output logic [sit_pkg::CASE_W-1:0]                  m_axis_tuser
);
    import sit_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [DW-1:0] n1_dx, n1_dy, n1_rx, n1_ry, n1_sx, n1_sy, n1_x32, n1_y32;
    logic n1_on_hit;

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [DW-1:0] r1_dx, r1_dy, r1_rx, r1_ry, r1_sx, r1_sy;
    logic r1_on_hit;

    logic signed [PW-1:0] r2_dx_ry, r2_dy_rx, r2_dx_sy, r2_dy_sx, r2_rx_sy, r2_ry_sx;
    logic r2_on_hit;

    logic signed [XW-1:0] n3_dxr, n3_dxs, n3_rxs;
    logic signed [XW-1:0] r3_dxr, r3_dxs, r3_rxs;
    logic r3_on_hit;

    logic n4_t_ok, n4_u_ok, n4_hit;
    logic [CASE_W-1:0] n4_code;
    logic r4_hit;
    logic [CASE_W-1:0] r4_code;

    assign x1 = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign y1 = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign x2 = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign y2 = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign x3 = s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign y3 = s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign x4 = s_axis_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign y4 = s_axis_tdata[7*COORD_WIDTH +: COORD_WIDTH];

    assign rdy4 = !r4_valid || m_axis_tready;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;
    assign s_axis_tready = rdy1;

    always_comb begin
        n1_dx  = {x3[COORD_WIDTH-1], x3} - {x1[COORD_WIDTH-1], x1};
        n1_dy  = {y3[COORD_WIDTH-1], y3} - {y1[COORD_WIDTH-1], y1};
        n1_rx  = {x2[COORD_WIDTH-1], x2} - {x1[COORD_WIDTH-1], x1};
        n1_ry  = {y2[COORD_WIDTH-1], y2} - {y1[COORD_WIDTH-1], y1};
        n1_sx  = {x4[COORD_WIDTH-1], x4} - {x3[COORD_WIDTH-1], x3};
        n1_sy  = {y4[COORD_WIDTH-1], y4} - {y3[COORD_WIDTH-1], y3};
        n1_x32 = {x3[COORD_WIDTH-1], x3} - {x2[COORD_WIDTH-1], x2};
        n1_y32 = {y3[COORD_WIDTH-1], y3} - {y2[COORD_WIDTH-1], y2};
        n1_on_hit = (n1_dx[DW-1] != n1_x32[DW-1]) || (n1_dy[DW-1] != n1_y32[DW-1]);
    end

    always_comb begin
        n3_dxr = {r2_dx_ry[PW-1], r2_dx_ry} - {r2_dy_rx[PW-1], r2_dy_rx};
        n3_dxs = {r2_dx_sy[PW-1], r2_dx_sy} - {r2_dy_sx[PW-1], r2_dy_sx};
        n3_rxs = {r2_rx_sy[PW-1], r2_rx_sy} - {r2_ry_sx[PW-1], r2_ry_sx};
    end

    // With a negative denominator both bounds flip, so no negation is needed.
    always_comb begin
        if (r3_rxs[XW-1]) begin
            n4_t_ok = (r3_dxs[XW-1] || (r3_dxs == '0)) && (r3_dxs >= r3_rxs);
            n4_u_ok = (r3_dxr[XW-1] || (r3_dxr == '0)) && (r3_dxr >= r3_rxs);
        end else begin
            n4_t_ok = !r3_dxs[XW-1] && (r3_dxs <= r3_rxs);
            n4_u_ok = !r3_dxr[XW-1] && (r3_dxr <= r3_rxs);
        end
        if (r3_dxr == '0) begin
            n4_hit  = r3_on_hit;
            n4_code = CASE_ON_LINE;
        end else if (r3_rxs == '0) begin
            n4_hit  = 1'b0;
            n4_code = CASE_PARALLEL;
        end else begin
            n4_hit  = n4_t_ok && n4_u_ok;
            n4_code = CASE_GENERAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= s_axis_tvalid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
            if (rdy4) r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r1_dx     <= n1_dx;
            r1_dy     <= n1_dy;
            r1_rx     <= n1_rx;
            r1_ry     <= n1_ry;
            r1_sx     <= n1_sx;
            r1_sy     <= n1_sy;
            r1_on_hit <= n1_on_hit;
        end
        if (rdy2 && r1_valid) begin
            r2_dx_ry  <= r1_dx * r1_ry;
            r2_dy_rx  <= r1_dy * r1_rx;
            r2_dx_sy  <= r1_dx * r1_sy;
            r2_dy_sx  <= r1_dy * r1_sx;
            r2_rx_sy  <= r1_rx * r1_sy;
            r2_ry_sx  <= r1_ry * r1_sx;
            r2_on_hit <= r1_on_hit;
        end
        if (rdy3 && r2_valid) begin
            r3_dxr    <= n3_dxr;
            r3_dxs    <= n3_dxs;
            r3_rxs    <= n3_rxs;
            r3_on_hit <= r2_on_hit;
        end
        if (rdy4 && r3_valid) begin
            r4_hit  <= n4_hit;
            r4_code <= n4_code;
        end
    end

    assign m_axis_tvalid = r4_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r4_hit};
    assign m_axis_tuser  = r4_code;

endmodule

// ===== hdl/sit_checker.sv =====
// Port-level assertions for the segment intersection block, bound to its top level.
`include "segment_intersection_test_assert.svh"

module sit_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sit_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [sit_pkg::CASE_W-1:0]         m_axis_tuser
);
    import sit_pkg::*;

    `SIT_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)
    `SIT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `SIT_ASSERT_IMPLY(a_parallel_no_hit, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == CASE_PARALLEL), !m_axis_tdata[0])
    `SIT_ASSERT_IMPLY(a_empty_out_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
